@@ design/kmc_pkg.sv @@
// ----------------------------------------------------------------------------
// kmc_pkg: shared types and constants of the k-mer histogram counter
// Op codes, command kinds and the records that travel between the front,
// the command queue and the count table back end.
// ----------------------------------------------------------------------------
package kmc_pkg;

	localparam int CODE_W      = 16;
	localparam int COUNT_W     = 32;
	localparam int TABLE_DEPTH = 65536;

	typedef enum logic [1:0] {
		OP_CHAR       = 2'd0,
		OP_NEW_READ   = 2'd1,
		OP_READ_ENTRY = 2'd2,
		OP_UNUSED     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_COUNT = 2'd1,
		CMD_READ  = 2'd2
	} cmd_kind_t;

	// code_a: forward code for a count, table index for a read
	// code_b: reverse complement code for a count
	typedef struct packed {
		cmd_kind_t          kind;
		logic [CODE_W-1:0]  code_a;
		logic [CODE_W-1:0]  code_b;
	} cmd_t;

	typedef struct packed {
		logic               kmer_valid;
		logic [CODE_W-1:0]  kmer_code;
		logic [CODE_W-1:0]  revcomp_code;
		logic [COUNT_W-1:0] count_value;
	} res_t;

endpackage

@@ design/kmc_ram.sv @@
// ----------------------------------------------------------------------------
// kmc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on a
// read of the address written in the same cycle).
// ----------------------------------------------------------------------------
module kmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/kmc_queue.sv @@
// ----------------------------------------------------------------------------
// kmc_queue: small register FIFO
// Holds packed requests between two sides that stall on their own.
// ----------------------------------------------------------------------------
module kmc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/kmc_front.sv @@
// ----------------------------------------------------------------------------
// kmc_front: request front end
// Accept requests, track the base window and run length, and turn each
// request into a count, read or no-op command for the back end.
// ----------------------------------------------------------------------------
module kmc_front #(
	parameter int KMER_LEN = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [1:0]                  op,
	input  logic [7:0]                  base_char,
	input  logic [kmc_pkg::CODE_W-1:0]  count_index,
	output kmc_pkg::cmd_t               cmd
);

	import kmc_pkg::*;

	localparam int WIN_W = 2 * KMER_LEN;
	localparam int RUN_W = (KMER_LEN > 1) ? $clog2(KMER_LEN) : 1;

	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;
	localparam logic [7:0] CHAR_T = 8'h54;

	logic [WIN_W-1:0] window_q;
	logic [RUN_W-1:0] run_q;
	logic [WIN_W-1:0] window_d;
	logic [RUN_W-1:0] run_d;
	logic [WIN_W-1:0] win_shift;
	logic [WIN_W-1:0] win_rc;
	logic             is_base;

	assign is_base   = (base_char == CHAR_A) || (base_char == CHAR_C) ||
	                   (base_char == CHAR_G) || (base_char == CHAR_T);
	assign win_shift = WIN_W'({window_q, base_char[2:1]});

	// reverse the 2-bit groups and complement each base
	always_comb begin
		for (int i = 0; i < KMER_LEN; i++) begin
			win_rc[2*i +: 2] = win_shift[2*(KMER_LEN-1-i) +: 2] ^ 2'b10;
		end
	end

	always_comb begin
		window_d    = window_q;
		run_d       = run_q;
		cmd.kind    = CMD_NONE;
		cmd.code_a  = '0;
		cmd.code_b  = '0;
		case (op)
			OP_CHAR: begin
				if (!is_base) begin
					window_d = '0;
					run_d    = '0;
				end else begin
					window_d = win_shift;
					if (run_q == RUN_W'(KMER_LEN - 1)) begin
						cmd.kind   = CMD_COUNT;
						cmd.code_a = CODE_W'(win_shift);
						cmd.code_b = CODE_W'(win_rc);
					end else begin
						run_d = run_q + 1'b1;
					end
				end
			end
			OP_NEW_READ: begin
				window_d = '0;
				run_d    = '0;
			end
			OP_READ_ENTRY: begin
				cmd.kind   = CMD_READ;
				cmd.code_a = count_index;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			run_q    <= '0;
		end else if (accept) begin
			window_q <= window_d;
			run_q    <= run_d;
		end
	end

endmodule

@@ design/kmc_back.sv @@
// ----------------------------------------------------------------------------
// kmc_back: count table back end
// Clear the table after reset, then carry out commands as read-modify-write
// passes on one table port, and queue results for the output.
// ----------------------------------------------------------------------------
module kmc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kmc_pkg::cmd_t               cmd,
	input  logic                        cmd_empty,
	output logic                        cmd_pop,
	output logic                        busy,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        kmer_valid,
	output logic [kmc_pkg::CODE_W-1:0]  kmer_code,
	output logic [kmc_pkg::CODE_W-1:0]  revcomp_code,
	output logic [kmc_pkg::COUNT_W-1:0] count_value
);

	import kmc_pkg::*;

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int RES_W  = $bits(res_t);

	// table clearing sweep
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// issue side
	logic              sub_q;
	logic              issue_res;
	logic              res_ok;
	logic              issue;
	logic [ADDR_W-1:0] rd_addr;

	// second stage
	logic              v_s2;
	logic              last_s2;
	logic              inc_s2;
	cmd_kind_t         kind_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [CODE_W-1:0] fi_s2;
	logic [CODE_W-1:0] ri_s2;

	// write bypass
	logic               wr_v_q;
	logic [ADDR_W-1:0]  wr_addr_q;
	logic [COUNT_W-1:0] wr_data_q;

	logic [COUNT_W-1:0] rdata;
	logic [COUNT_W-1:0] base;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [COUNT_W-1:0] ram_wdata;

	res_t res;
	res_t res_head;
	logic out_full;
	logic out_empty;
	logic out_pop;
	logic res_push;

	assign busy = clearing_q;

	// a count issues twice: forward index, then reverse complement index
	assign issue_res = (cmd.kind == CMD_COUNT) ? sub_q : 1'b1;
	// issue a result pass only when the output queue has room for it next cycle
	assign res_ok    = out_empty || (!out_full && (!res_push || out_pop)) ||
	                   (out_pop && !res_push);
	assign issue     = !clearing_q && !cmd_empty && (!issue_res || res_ok);
	assign cmd_pop   = issue && issue_res;
	assign rd_addr   = (cmd.kind == CMD_COUNT && sub_q) ? ADDR_W'(cmd.code_b)
	                                                    : ADDR_W'(cmd.code_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			sub_q      <= 1'b0;
			v_s2       <= 1'b0;
			wr_v_q     <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (issue && cmd.kind == CMD_COUNT) begin
				sub_q <= ~sub_q;
			end
			v_s2   <= issue;
			wr_v_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		last_s2   <= issue_res;
		inc_s2    <= (cmd.kind == CMD_COUNT);
		kind_s2   <= cmd.kind;
		addr_s2   <= rd_addr;
		fi_s2     <= cmd.code_a;
		ri_s2     <= cmd.code_b;
		wr_addr_q <= ram_waddr;
		wr_data_q <= ram_wdata;
	end

	// take last cycle's write when the table returned stale data
	assign base = (wr_v_q && wr_addr_q == addr_s2) ? wr_data_q : rdata;

	always_comb begin
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = v_s2 && inc_s2;
			ram_waddr = addr_s2;
			ram_wdata = base + 1'b1;
		end
	end

	kmc_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_comb begin
		res.kmer_valid   = (kind_s2 == CMD_COUNT);
		res.kmer_code    = (kind_s2 == CMD_COUNT) ? fi_s2 : '0;
		res.revcomp_code = (kind_s2 == CMD_COUNT) ? ri_s2 : '0;
		res.count_value  = (kind_s2 == CMD_READ) ? base : '0;
	end

	assign res_push = v_s2 && last_s2;
	assign out_pop  = out_valid && out_ready;

	kmc_queue #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.pop       (out_pop),
		.pop_data  (res_head),
		.full      (out_full),
		.empty     (out_empty)
	);

	assign out_valid    = !out_empty;
	assign kmer_valid   = res_head.kmer_valid;
	assign kmer_code    = res_head.kmer_code;
	assign revcomp_code = res_head.revcomp_code;
	assign count_value  = res_head.count_value;

endmodule

@@ design/kmer_histogram_counter.sv @@
// ----------------------------------------------------------------------------
// kmer_histogram_counter: k-mer counter with reverse complement
// Counts every k-mer of a stream of DNA reads, and its reverse complement,
// in a 64K-entry table of 32-bit wrapping counts that can be read back.
// ----------------------------------------------------------------------------
// After reset the block clears the count table, one entry per cycle, with
// in_ready low. After that every request (character, start of read, table
// read) returns exactly one result, in request order. A character that
// completes a k-mer takes two passes of the back end, since the forward and
// reverse complement counts are two read-modify-write passes through the
// single write port of the count table; every other request takes a single
// pass there. A request goes through the command queue, the second stage
// registers and the output queue before out_valid rises. A palindromic k-mer
// gains 2. Only uppercase A, C, G, T are bases; any other character or a
// start of read clears the k-mer window.
// ----------------------------------------------------------------------------
module kmer_histogram_counter #(
	parameter int KMER_LEN = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [7:0]                  base_char,
	input  logic [kmc_pkg::CODE_W-1:0]  count_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        kmer_valid,
	output logic [kmc_pkg::CODE_W-1:0]  kmer_code,
	output logic [kmc_pkg::CODE_W-1:0]  revcomp_code,
	output logic [kmc_pkg::COUNT_W-1:0] count_value
);

	import kmc_pkg::*;

	localparam int CMD_W     = $bits(cmd_t);
	localparam int CMD_DEPTH = 4;

	cmd_t front_cmd;
	cmd_t back_cmd;
	logic accept;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;
	logic busy;

	// hold off requests while the table clears or the command queue is full
	assign in_ready = !busy && !cmd_full;
	assign accept   = in_valid && in_ready;

	// classify each request and advance the k-mer window
	kmc_front #(
		.KMER_LEN (KMER_LEN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (op),
		.base_char   (base_char),
		.count_index (count_index),
		.cmd         (front_cmd)
	);

	// decouple the front from the table passes
	kmc_queue #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (front_cmd),
		.pop       (cmd_pop),
		.pop_data  (back_cmd),
		.full      (cmd_full),
		.empty     (cmd_empty)
	);

	// update and read the count table, drive results
	kmc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (back_cmd),
		.cmd_empty    (cmd_empty),
		.cmd_pop      (cmd_pop),
		.busy         (busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kmer_valid   (kmer_valid),
		.kmer_code    (kmer_code),
		.revcomp_code (revcomp_code),
		.count_value  (count_value)
	);

endmodule
